// ===== sv/pmq_pkg.sv =====
// Shared types and constants for the permutation move-and-query block.
package pmq_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int ITEM_W    = ADDR_W;
    localparam int LEN_W     = 11;
    localparam int POS_W     = 10;
    localparam int VAL_W     = 10;
    localparam int CMP_W     = (LEN_W > ADDR_W + 1) ? LEN_W : ADDR_W + 1;

    localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(1024);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_ITEMS - 1);

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_MOVE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] target;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             out_of_range;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_MFIRST,
        ST_MSHIFT,
        ST_MPUT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ITEM_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

// ===== sv/pmq_ram.sv =====
// Order store: one write port, one read port with registered read data.
module pmq_ram
    import pmq_pkg::*;
(
    input  logic              clk,
    input  ram_wr_t           wr,
    input  ram_rd_t           rd,
    output logic [ITEM_W-1:0] rd_data
);

    logic [ITEM_W-1:0] mem [MAX_ITEMS];
    logic [ITEM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/pmq_ctrl.sv =====
// Sequencer: store clearing pass, query lookup and entry-by-entry shift for moves.
module pmq_ctrl
    import pmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic [CMP_W-1:0]  len_eff,
    output ram_wr_t           wr,
    output ram_rd_t           rd,
    input  logic [ITEM_W-1:0] rd_data
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] tgt_reg, tgt_next;
    logic              up_reg, up_next;
    logic [ITEM_W-1:0] moved_reg, moved_next;
    logic              oor_reg, oor_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [ADDR_W-1:0] step;
    logic              pos_ok, tgt_ok;

    // shared stepper: read pointer one place toward the target
    assign step   = rp_reg + (up_reg ? ADDR_W'(1) : {ADDR_W{1'b1}});
    assign pos_ok = CMP_W'(in_item.position) < len_eff;
    assign tgt_ok = CMP_W'(in_item.target) < len_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg    <= rp_next;
        tgt_reg   <= tgt_next;
        up_reg    <= up_next;
        moved_reg <= moved_next;
        oor_reg   <= oor_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rp_next        = rp_reg;
        tgt_next       = tgt_reg;
        up_next        = up_reg;
        moved_next     = moved_reg;
        oor_next       = oor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        rd.en          = 1'b0;
        rd.addr        = rp_reg;
        wr.en          = 1'b0;
        wr.addr        = idx_reg;
        wr.data        = rd_data;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.data  = ITEM_W'(idx_reg);
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd.addr  = ADDR_W'(in_item.position);
                if (in_valid)
                begin
                    if (in_item.op == OP_QUERY)
                    begin
                        rd.en      = pos_ok;
                        oor_next   = !pos_ok;
                        state_next = ST_QRD;
                    end
                    else if (pos_ok && tgt_ok && (in_item.position != in_item.target))
                    begin
                        rd.en      = 1'b1;
                        idx_next   = ADDR_W'(in_item.position);
                        rp_next    = ADDR_W'(in_item.position);
                        tgt_next   = ADDR_W'(in_item.target);
                        up_next    = in_item.target > in_item.position;
                        state_next = ST_MFIRST;
                    end
                end
            end
            ST_QRD:
            begin
                // read data is held until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_next.value        = oor_reg ? '0 : VAL_W'(rd_data);
                    out_next.out_of_range = oor_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_MFIRST:
            begin
                moved_next = rd_data;
                rd.en      = 1'b1;
                rd.addr    = step;
                rp_next    = step;
                state_next = ST_MSHIFT;
            end
            ST_MSHIFT:
            begin
                // write entry idx from its neighbor while the next one is read
                wr.en    = 1'b1;
                idx_next = rp_reg;
                if (rp_reg == tgt_reg)
                begin
                    state_next = ST_MPUT;
                end
                else
                begin
                    rd.en   = 1'b1;
                    rd.addr = step;
                    rp_next = step;
                end
            end
            ST_MPUT:
            begin
                wr.en      = 1'b1;
                wr.addr    = tgt_reg;
                wr.data    = moved_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== sv/permutation_move_and_query.sv =====
// Top level of the permutation list: length register, sequencer and order store.
//
// Keeps an ordered list of item numbers, identity order after reset.
// Input channel (in_valid/in_ready/in_item): a query item asks for the number
// at a position; a move item takes the entry at position out and reinserts it
// so it lands on target. Output channel (out_valid/out_ready/out_item): one
// item per query, none per move. Out-of-range queries return value 0 with
// out_of_range set; out-of-range moves are dropped.
// Query path: the order store registers the read at accept, then the sequencer
// loads the result into the output register, which drives out_valid.
// A move occupies the block while it shifts the entries from position to
// target, bound by the single write port of the order store, which moves one
// entry per cycle. Reset: a clearing pass writes entry i = i for all MAX_ITEMS
// (1024) entries, with in_ready low; cfg_we writes list_length at any time
// (reset value 1024).
// Receiver stall: a finished result waits in the output register; the block
// still takes moves, and a following query waits in the sequencer until the
// output register is free.
module permutation_move_and_query
    import pmq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    logic [LEN_W-1:0]  list_length_reg;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  len_eff;
    ram_wr_t           wr;
    ram_rd_t           rd;
    logic [ITEM_W-1:0] rd_data;

    // list length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            list_length_reg <= cfg_wdata;
        end
    end

    // length in use is capped at the store depth
    assign len_ext = CMP_W'(list_length_reg);
    assign len_eff = (len_ext > CMP_W'(MAX_ITEMS)) ? CMP_W'(MAX_ITEMS) : len_ext;

    pmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .len_eff   (len_eff),
        .wr        (wr),
        .rd        (rd),
        .rd_data   (rd_data)
    );

    pmq_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // an accepted query holds the input off for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.op == OP_QUERY) |=> !in_ready)
        else $error("in_ready high right after query accept");

    // moves never raise a result
    a_move_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.op == OP_MOVE) |=> !$rose(out_valid))
        else $error("result raised by a move");

    // a query into an empty output register is answered without waiting in the sequencer
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.op == OP_QUERY && !out_valid) |-> ##2 out_valid)
        else $error("query result late");

    // flagged results carry value zero
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.out_of_range) |-> (out_item.value == '0))
        else $error("out-of-range result with nonzero value");

endmodule
